// ===== rtl/core/kpv_pkg.sv =====
// kpv_pkg: shared types, constants and saturation helpers for the
// position/velocity Kalman filter core. No dependencies.
`default_nettype none

package kpv_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_BITS  = 32;
  localparam int FIELD_BITS = 32;
  localparam int STEP_BITS  = 17;
  localparam int NOISE_BITS = 31;
  localparam int CFG_BITS   = 32;
  localparam int CFG_IDX_BITS = 3;

  localparam int DIV_STEPS    = (WORD_BITS + FRAC_BITS + 1) / 2;
  localparam int DIV_BITS     = 2 * DIV_STEPS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  typedef logic signed [WORD_BITS-1:0]  word_t;
  typedef logic signed [FIELD_BITS-1:0] field_t;

  typedef struct packed {
    field_t measured_velocity;
    field_t accel_command;
  } kpv_in_t;

  typedef struct packed {
    field_t position_estimate;
    field_t velocity_estimate;
  } kpv_out_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STEP_TIME,
    CFG_Q_POS,
    CFG_Q_VEL,
    CFG_R_MEAS,
    CFG_INIT_POS,
    CFG_INIT_VEL,
    CFG_INIT_VAR
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ALU_MAC,
    ALU_MSU,
    ALU_HALF
  } alu_op_t;

  localparam logic signed [63:0] W_MAX64 = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] W_MIN64 = -W_MAX64 - 64'sd1;
  localparam logic signed [63:0] F_MAX64 = (64'sd1 <<< (FIELD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] F_MIN64 = -F_MAX64 - 64'sd1;

  localparam word_t ONE = word_t'(64'sd1 <<< FRAC_BITS);

  function automatic word_t clamp_word(input logic signed [63:0] v);
    word_t res;
    if (v > W_MAX64) begin
      res = word_t'(W_MAX64);
    end else if (v < W_MIN64) begin
      res = word_t'(W_MIN64);
    end else begin
      res = v[WORD_BITS-1:0];
    end
    return res;
  endfunction

  function automatic field_t clamp_field(input word_t w);
    logic signed [63:0] v;
    field_t res;
    v = 64'(w);
    if (v > F_MAX64) begin
      res = field_t'(F_MAX64);
    end else if (v < F_MIN64) begin
      res = field_t'(F_MIN64);
    end else begin
      res = v[FIELD_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kpv_alu.sv =====
// kpv_alu: shared fixed-point multiply / saturating accumulate unit.
// Product registered; shift-saturate and add, subtract or halve on the next cycle. Uses kpv_pkg.
`default_nettype none

module kpv_alu (
  input  logic              clk,
  input  kpv_pkg::alu_op_t  op,
  input  kpv_pkg::word_t    a,
  input  kpv_pkg::word_t    b,
  input  kpv_pkg::word_t    c,
  output kpv_pkg::word_t    result
);
  import kpv_pkg::*;

  localparam logic [2*WORD_BITS-1:0] LIM_NEG =
    {{WORD_BITS{1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [2*WORD_BITS-1:0] LIM_POS = LIM_NEG - 1'b1;

  logic [WORD_BITS-1:0]   ua, ub, mag_a, mag_b, mag;
  logic [2*WORD_BITS-1:0] prod_nxt, prod_r, shifted, limit;
  logic                   neg_r;
  alu_op_t                op_r;
  word_t                  c_r;
  logic signed [WORD_BITS:0]   p_ext, p, p_half;
  logic signed [WORD_BITS+1:0] c_ext, p_ext2, sum;

  assign ua       = a;
  assign ub       = b;
  assign mag_a    = a[WORD_BITS-1] ? (~ua + 1'b1) : ua;
  assign mag_b    = b[WORD_BITS-1] ? (~ub + 1'b1) : ub;
  assign prod_nxt = mag_a * mag_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
    op_r   <= op;
    c_r    <= c;
  end

  always_comb begin
    shifted = prod_r >> FRAC_BITS;
    limit   = neg_r ? LIM_NEG : LIM_POS;
    mag     = (shifted > limit) ? limit[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
    p_ext   = signed'({1'b0, mag});
    p       = neg_r ? -p_ext : p_ext;
    p_half  = p >>> 1;
    c_ext   = {c_r[WORD_BITS-1], c_r[WORD_BITS-1], c_r};
    p_ext2  = {p[WORD_BITS], p};
    sum     = (op_r == ALU_MSU) ? (c_ext - p_ext2) : (c_ext + p_ext2);
    case (op_r)
      ALU_HALF: result = p_half[WORD_BITS-1:0];
      default:  result = clamp_word(64'(sum));
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/kpv_div.sv =====
// kpv_div: iterative restoring divider, two quotient bits per cycle.
// Computes sat((n << FRAC_BITS) / d) for d > 0. Uses kpv_pkg.
`default_nettype none

module kpv_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  kpv_pkg::word_t  numer,
  input  kpv_pkg::word_t  denom,
  output logic            busy,
  output logic            done,
  output kpv_pkg::word_t  quot
);
  import kpv_pkg::*;

  localparam logic [DIV_BITS-1:0] LIM_NEG = DIV_BITS'({1'b1, {(WORD_BITS-1){1'b0}}});
  localparam logic [DIV_BITS-1:0] LIM_POS = LIM_NEG - 1'b1;

  logic                    busy_r, done_r, neg_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic [WORD_BITS-1:0]    rem_r, rem_nxt, den_r, un, mag_n, rem1, qmag;
  logic [DIV_BITS-1:0]     dvd_r, dvd_nxt, limit, qsat;
  logic [WORD_BITS:0]      r1, r1s, r2, r2s, den_ext;
  logic                    ge1, ge2;

  assign un    = numer;
  assign mag_n = numer[WORD_BITS-1] ? (~un + 1'b1) : un;

  always_comb begin
    den_ext = {1'b0, den_r};
    r1      = {rem_r, dvd_r[DIV_BITS-1]};
    ge1     = (r1 >= den_ext);
    r1s     = ge1 ? (r1 - den_ext) : r1;
    rem1    = r1s[WORD_BITS-1:0];
    r2      = {rem1, dvd_r[DIV_BITS-2]};
    ge2     = (r2 >= den_ext);
    r2s     = ge2 ? (r2 - den_ext) : r2;
    rem_nxt = r2s[WORD_BITS-1:0];
    dvd_nxt = {dvd_r[DIV_BITS-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= numer[WORD_BITS-1];
      den_r <= denom;
      rem_r <= '0;
      dvd_r <= DIV_BITS'({mag_n, {FRAC_BITS{1'b0}}});
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  always_comb begin
    limit = neg_r ? LIM_NEG : LIM_POS;
    qsat  = (dvd_r > limit) ? limit : dvd_r;
    qmag  = qsat[WORD_BITS-1:0];
    quot  = word_t'(neg_r ? (~qmag + 1'b1) : qmag);
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

`default_nettype wire

// ===== rtl/core/kalman_pos_vel_filter_core.sv =====
// kalman_pos_vel_filter_core: two-state position/velocity Kalman filter,
// sequenced over one shared multiply-accumulate unit and one divider.
// Depends on kpv_pkg, kpv_alu, kpv_div.
//
//   port group   dir  handshake           word
//   in_*         in   in_valid/in_ready   kpv_in_t  (measurement, accel)
//   out_*        out  out_valid/out_ready kpv_out_t (position, velocity)
//   cfg_*        in   cfg_we              cfg_idx selects register, cfg_wdata
//
// Per word, the idle state accepts the word, two divisions compute the
// gains and dominate the run time, the rest is 16 passes through the
// shared MAC unit and one emit step.
// With a non-positive innovation variance the divisions are skipped.
// in_ready is high only in idle. Output register holds the result while the
// prediction runs; a new result waits until the previous word is taken.
// Synchronous active-low reset; first word after reset loads initial state.
`default_nettype none

module kalman_pos_vel_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  kpv_pkg::kpv_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output kpv_pkg::kpv_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [kpv_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [kpv_pkg::CFG_BITS-1:0]        cfg_wdata
);
  import kpv_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GAIN_S,
    ST_DIV_K0,
    ST_DIV_K1,
    ST_INNOV,
    ST_POS,
    ST_VEL,
    ST_PP,
    ST_PV,
    ST_VV,
    ST_EMIT,
    ST_HALF,
    ST_PRED_P0,
    ST_PRED_P1,
    ST_PRED_V,
    ST_COV_PP0,
    ST_COV_PV,
    ST_COV_PP1,
    ST_COV_PPQ,
    ST_COV_VVQ
  } state_t;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;
  logic   started_r, out_valid_r;
  kpv_out_t out_data_r;

  logic [STEP_BITS-1:0]  step_time_r;
  logic [NOISE_BITS-1:0] q_pos_r, q_vel_r, r_meas_r, init_var_r;
  field_t                init_pos_r, init_vel_r;

  word_t ppos_r, pvel_r, pp_r, pv_r, vv_r;
  word_t z_r, u_r, s_r, k0_r, k1_r, e_r, pos_r, vel_r, half_r;

  word_t dt_w, q_pos_w, q_vel_w, r_meas_w, init_var_w;
  logic  s_pos;

  alu_op_t alu_op;
  word_t   alu_a, alu_b, alu_c, alu_res;
  logic    div_start, div_busy, div_done;
  word_t   div_quot;

  assign dt_w       = clamp_word(64'(signed'({1'b0, step_time_r})));
  assign q_pos_w    = clamp_word(64'(signed'({1'b0, q_pos_r})));
  assign q_vel_w    = clamp_word(64'(signed'({1'b0, q_vel_r})));
  assign r_meas_w   = clamp_word(64'(signed'({1'b0, r_meas_r})));
  assign init_var_w = clamp_word(64'(signed'({1'b0, init_var_r})));
  assign s_pos      = !s_r[WORD_BITS-1] && (s_r != '0);

  kpv_alu u_alu (
    .clk    (clk),
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .c      (alu_c),
    .result (alu_res)
  );

  kpv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer ((state_r == ST_DIV_K0) ? pv_r : vv_r),
    .denom (s_r),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign div_start = ((state_r == ST_DIV_K0) || (state_r == ST_DIV_K1)) && !phase_r && s_pos;

  // operand select
  always_comb begin
    alu_op = ALU_MAC;
    alu_a  = '0;
    alu_b  = '0;
    alu_c  = '0;
    case (state_r)
      ST_GAIN_S:  begin alu_a = r_meas_w; alu_b = ONE;  alu_c = vv_r;   end
      ST_INNOV:   begin alu_op = ALU_MSU; alu_a = pvel_r; alu_b = ONE; alu_c = z_r; end
      ST_POS:     begin alu_a = k0_r;     alu_b = e_r;  alu_c = ppos_r; end
      ST_VEL:     begin alu_a = k1_r;     alu_b = e_r;  alu_c = pvel_r; end
      ST_PP:      begin alu_op = ALU_MSU; alu_a = k0_r; alu_b = pv_r; alu_c = pp_r; end
      ST_PV:      begin alu_op = ALU_MSU; alu_a = k1_r; alu_b = pv_r; alu_c = pv_r; end
      ST_VV:      begin alu_op = ALU_MSU; alu_a = k1_r; alu_b = vv_r; alu_c = vv_r; end
      ST_HALF:    begin alu_op = ALU_HALF; alu_a = dt_w; alu_b = dt_w; end
      ST_PRED_P0: begin alu_a = dt_w;     alu_b = vel_r; alu_c = pos_r;  end
      ST_PRED_P1: begin alu_a = half_r;   alu_b = u_r;   alu_c = ppos_r; end
      ST_PRED_V:  begin alu_a = dt_w;     alu_b = u_r;   alu_c = vel_r;  end
      ST_COV_PP0: begin alu_a = dt_w;     alu_b = pv_r;  alu_c = pp_r;   end
      ST_COV_PV:  begin alu_a = dt_w;     alu_b = vv_r;  alu_c = pv_r;   end
      ST_COV_PP1: begin alu_a = dt_w;     alu_b = pv_r;  alu_c = pp_r;   end
      ST_COV_PPQ: begin alu_a = q_pos_w;  alu_b = ONE;   alu_c = pp_r;   end
      ST_COV_VVQ: begin alu_a = q_vel_w;  alu_b = ONE;   alu_c = vv_r;   end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_GAIN_S;
          phase_nxt = 1'b0;
        end
      end
      ST_DIV_K0, ST_DIV_K1: begin
        if (!s_pos) begin
          state_nxt = ST_INNOV;
          phase_nxt = 1'b0;
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
        end else if (div_done) begin
          state_nxt = (state_r == ST_DIV_K0) ? ST_DIV_K1 : ST_INNOV;
          phase_nxt = 1'b0;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_HALF;
          phase_nxt = 1'b0;
        end
      end
      default: begin
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          case (state_r)
            ST_GAIN_S:  state_nxt = ST_DIV_K0;
            ST_INNOV:   state_nxt = ST_POS;
            ST_POS:     state_nxt = ST_VEL;
            ST_VEL:     state_nxt = ST_PP;
            ST_PP:      state_nxt = ST_PV;
            ST_PV:      state_nxt = ST_VV;
            ST_VV:      state_nxt = ST_EMIT;
            ST_HALF:    state_nxt = ST_PRED_P0;
            ST_PRED_P0: state_nxt = ST_PRED_P1;
            ST_PRED_P1: state_nxt = ST_PRED_V;
            ST_PRED_V:  state_nxt = ST_COV_PP0;
            ST_COV_PP0: state_nxt = ST_COV_PV;
            ST_COV_PV:  state_nxt = ST_COV_PP1;
            ST_COV_PP1: state_nxt = ST_COV_PPQ;
            ST_COV_PPQ: state_nxt = ST_COV_VVQ;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      step_time_r <= STEP_BITS'(6554);
      q_pos_r     <= NOISE_BITS'(65536);
      q_vel_r     <= NOISE_BITS'(65536);
      r_meas_r    <= NOISE_BITS'(6554);
      init_pos_r  <= '0;
      init_vel_r  <= FIELD_BITS'(51118);
      init_var_r  <= NOISE_BITS'(65536);
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;

      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_STEP_TIME: step_time_r <= cfg_wdata[STEP_BITS-1:0];
          CFG_Q_POS:     q_pos_r     <= cfg_wdata[NOISE_BITS-1:0];
          CFG_Q_VEL:     q_vel_r     <= cfg_wdata[NOISE_BITS-1:0];
          CFG_R_MEAS:    r_meas_r    <= cfg_wdata[NOISE_BITS-1:0];
          CFG_INIT_POS:  init_pos_r  <= cfg_wdata[FIELD_BITS-1:0];
          CFG_INIT_VEL:  init_vel_r  <= cfg_wdata[FIELD_BITS-1:0];
          CFG_INIT_VAR:  init_var_r  <= cfg_wdata[NOISE_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            z_r <= clamp_word(64'(in_data.measured_velocity));
            u_r <= clamp_word(64'(in_data.accel_command));
            if (!started_r) begin
              started_r <= 1'b1;
              ppos_r    <= clamp_word(64'(init_pos_r));
              pvel_r    <= clamp_word(64'(init_vel_r));
              pp_r      <= init_var_w;
              pv_r      <= '0;
              vv_r      <= init_var_w;
            end
          end
        end
        ST_DIV_K0: begin
          if (!s_pos) begin
            k0_r <= '0;
            k1_r <= '0;
          end else if (phase_r && div_done) begin
            k0_r <= div_quot;
          end
        end
        ST_DIV_K1: begin
          if (phase_r && div_done) begin
            k1_r <= div_quot;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                  <= 1'b1;
            out_data_r.position_estimate <= clamp_field(pos_r);
            out_data_r.velocity_estimate <= clamp_field(vel_r);
          end
        end
        default: begin
          if (phase_r) begin
            case (state_r)
              ST_GAIN_S:  s_r    <= alu_res;
              ST_INNOV:   e_r    <= alu_res;
              ST_POS:     pos_r  <= alu_res;
              ST_VEL:     vel_r  <= alu_res;
              ST_HALF:    half_r <= alu_res;
              ST_PP, ST_COV_PP0, ST_COV_PP1, ST_COV_PPQ: pp_r <= alu_res;
              ST_PV, ST_COV_PV:        pv_r   <= alu_res;
              ST_VV, ST_COV_VVQ:       vv_r   <= alu_res;
              ST_PRED_P0, ST_PRED_P1:  ppos_r <= alu_res;
              ST_PRED_V:               pvel_r <= alu_res;
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy)
    else $error("divider busy while core idle");

  a_div_done_place: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_K0 || state_r == ST_DIV_K1))
    else $error("divider result outside gain states");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && state_nxt == ST_HALF) |=> out_valid)
    else $error("result not presented after emit");

  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (started_r && state_r == ST_GAIN_S))
    else $error("accepted word did not start the filter");

endmodule

`default_nettype wire
